// ===== design/substring_occurrence_counter_top_assert.svh =====
// Assertion macros for the substring occurrence counter
`ifndef SUBSTRING_OCCURRENCE_COUNTER_TOP_ASSERT_SVH
`define SUBSTRING_OCCURRENCE_COUNTER_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SOC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("substring counter check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define SOC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("substring counter check failed");

`endif

// ===== design/soc_pkg.sv =====
// Shared types and constants for the substring occurrence counter
`timescale 1ns / 1ps
`default_nettype none

package soc_pkg;

  localparam int unsigned NEEDLE_MAX_DEF = 16;
  localparam int unsigned NEEDLE_REGS    = 16;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned COUNT_W    = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_NEEDLE_LO  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NEEDLE_HI  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NEEDLE_LEN = 2'd2;

  typedef logic [7:0]                  byte_t;
  typedef logic [NEEDLE_REGS-1:0][7:0] needle_t;
  typedef logic [LEN_W-1:0]            len_t;

endpackage

`default_nettype wire

// ===== design/soc_cell.sv =====
// One window cell: holds one byte and compares the byte arriving at it
`timescale 1ns / 1ps
`default_nettype none

module soc_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             shift_en,
  input  wire soc_pkg::byte_t   byte_in,
  input  wire soc_pkg::needle_t needle,
  input  wire soc_pkg::len_t    needle_len,
  output soc_pkg::byte_t        byte_out,
  output logic                  eq
);

  localparam soc_pkg::len_t IDX_L = soc_pkg::len_t'(IDX);

  soc_pkg::byte_t byte_r;
  soc_pkg::len_t  pat_idx;

  // this cell lines up with needle byte len-1-IDX once the new byte is in
  assign pat_idx = needle_len - IDX_L - soc_pkg::len_t'(1);
  assign eq      = (IDX_L >= needle_len) || (byte_in == needle[pat_idx[3:0]]);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

endmodule

`default_nettype wire

// ===== design/substring_occurrence_counter_top.sv =====
// Each accepted byte's result word is registered straight into the output register.
// Throughput: one byte per cycle; the output register accepts a new word while
// the previous one is being taken, so a stall only blocks when it is still held.
// Reset (rst_n low, synchronous): clears counters, skip, stop flag and needle
// registers; window bytes are gated by the fill count and need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module substring_occurrence_counter_top #(
  parameter int unsigned NEEDLE_MAX = soc_pkg::NEEDLE_MAX_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] data_byte
  input  wire logic                             in_tlast,   // last
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [soc_pkg::COUNT_W-1:0]           out_tdata,  // [31:0] running_count
  output logic [0:0]                            out_tuser,  // [0] match_end
  output logic                                  out_tlast,  // buffer_done
  // configuration
  input  wire logic                             cfg_wr_en,
  input  wire logic [soc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [soc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(NEEDLE_MAX + 1);
  localparam logic [CNT_W-1:0] SEEN_FULL = CNT_W'(NEEDLE_MAX);
  localparam soc_pkg::len_t    LEN_MAX   = soc_pkg::len_t'(NEEDLE_MAX);

  // configuration registers
  logic [63:0]     needle_lo_r;
  logic [63:0]     needle_hi_r;
  soc_pkg::len_t   needle_len_r;
  soc_pkg::needle_t needle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_lo_r  <= '0;
      needle_hi_r  <= '0;
      needle_len_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        soc_pkg::REG_NEEDLE_LO:  needle_lo_r  <= cfg_wdata;
        soc_pkg::REG_NEEDLE_HI:  needle_hi_r  <= cfg_wdata;
        soc_pkg::REG_NEEDLE_LEN: needle_len_r <= cfg_wdata[soc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign needle = {needle_hi_r, needle_lo_r};

  // handshake
  logic in_accept;
  assign in_tready = !out_tvalid || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // cell chain: link[j] is the byte entering cell j
  soc_pkg::byte_t          link [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0]   cell_eq;

  assign link[0] = in_tdata;

  for (genvar j = 0; j < NEEDLE_MAX; j++) begin : g_cell
    if (j < NEEDLE_MAX - 1) begin : g_mid
      soc_cell #(.IDX(j)) u_cell (
        .clk        (clk),
        .shift_en   (in_accept),
        .byte_in    (link[j]),
        .needle     (needle),
        .needle_len (needle_len_r),
        .byte_out   (link[j+1]),
        .eq         (cell_eq[j])
      );
    end else begin : g_end
      soc_cell #(.IDX(j)) u_cell (
        .clk        (clk),
        .shift_en   (in_accept),
        .byte_in    (link[j]),
        .needle     (needle),
        .needle_len (needle_len_r),
        .byte_out   (),
        .eq         (cell_eq[j])
      );
    end
  end

  // scan state
  logic [CNT_W-1:0]            seen_r,  seen_nxt;
  logic [CNT_W-1:0]            skip_r,  skip_nxt;
  logic [soc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                        stop_r,  stop_nxt;
  logic                        len_ok;
  logic                        hit;

  assign len_ok = (needle_len_r != '0) && (needle_len_r <= LEN_MAX);

  always_comb begin
    seen_nxt  = (seen_r == SEEN_FULL) ? seen_r : seen_r + CNT_W'(1);
    stop_nxt  = stop_r || (in_tdata == '0);
    skip_nxt  = skip_r;
    count_nxt = count_r;
    hit       = 1'b0;
    if (!stop_nxt) begin
      if (skip_r != '0) begin
        skip_nxt = skip_r - CNT_W'(1);
      end else if (len_ok && (soc_pkg::len_t'(seen_nxt) >= needle_len_r) && (&cell_eq)) begin
        hit       = 1'b1;
        skip_nxt  = needle_len_r[CNT_W-1:0] - CNT_W'(1);
        count_nxt = (&count_r) ? count_r : count_r + soc_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      skip_r  <= '0;
      count_r <= '0;
      stop_r  <= 1'b0;
    end else if (in_accept) begin
      if (in_tlast) begin
        seen_r  <= '0;
        skip_r  <= '0;
        count_r <= '0;
        stop_r  <= 1'b0;
      end else begin
        seen_r  <= seen_nxt;
        skip_r  <= skip_nxt;
        count_r <= count_nxt;
        stop_r  <= stop_nxt;
      end
    end
  end

  // output word register
  logic                        out_valid_r;
  logic                        match_r;
  logic [soc_pkg::COUNT_W-1:0] out_count_r;
  logic                        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      match_r     <= hit;
      out_count_r <= count_nxt;
      done_r      <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_count_r;
  assign out_tuser  = match_r;
  assign out_tlast  = done_r;

`include "substring_occurrence_counter_top_assert.svh"

  // a flagged match always leaves a nonzero count
  `SOC_ASSERT_NOW(a_match_count, out_tvalid && out_tuser[0], out_tdata != '0)
  // a byte taken during the skip after a match never matches itself
  `SOC_ASSERT_NEXT(a_skip_no_hit, in_accept && (skip_r != '0), !out_tuser[0])
  // closing a buffer leaves the scan state empty
  `SOC_ASSERT_NEXT(a_last_clears, in_accept && in_tlast,
                   (count_r == '0) && (seen_r == '0) && (skip_r == '0) && !stop_r)

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking bench for the non-overlapping substring counter: directed script, then random
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NMAX         = soc_pkg::NEEDLE_MAX_DEF;
  localparam int unsigned RAND_PHASES  = 16;
  localparam int unsigned PHASE_BYTES  = 76;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam logic [soc_pkg::CFG_ADDR_W-1:0] REG_SPARE = 2'd3;  // unmapped index

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum {ROW_NEEDLE, ROW_BYTE} row_kind_t;

  typedef struct {
    logic                        match_end;
    logic [soc_pkg::COUNT_W-1:0] count;
    logic                        done;
  } count_word_t;

  typedef struct {
    row_kind_t                   kind;
    logic [63:0]                 lo;
    logic [63:0]                 hi;
    logic [63:0]                 len_word;
    soc_pkg::byte_t              data;
    bit                          last;
    bit                          typed;
    bit                          exp_match;
    logic [soc_pkg::COUNT_W-1:0] exp_count;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [soc_pkg::COUNT_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [soc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [soc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  substring_occurrence_counter_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] data_byte
    .in_tlast   (in_tlast),   // last
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [31:0] running_count
    .out_tuser  (out_tuser),  // [0] match_end
    .out_tlast  (out_tlast),  // buffer_done
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow of the block
  soc_pkg::needle_t            needle_sh = '0;
  soc_pkg::len_t               nlen = '0;
  soc_pkg::byte_t              win [NMAX];
  int unsigned                 fill = 0;
  int unsigned                 skip = 0;
  logic [soc_pkg::COUNT_W-1:0] occ_count = '0;
  bit                          stopped = 1'b0;

  count_word_t pending_words [$];
  int unsigned err_count = 0;
  idle_mode_t  idle_mode = IDLE_NONE;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet = 0;

  initial begin
    foreach (win[k]) win[k] = '0;
  end

  function automatic count_word_t scan_byte(soc_pkg::byte_t b, bit is_last);
    count_word_t w;
    bit hit;
    bit same;
    int k;
    hit = 1'b0;
    for (k = NMAX - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = b;
    if (fill < NMAX) fill++;
    if (b == 8'h00) stopped = 1'b1;
    if (!stopped) begin
      if (skip > 0) begin
        skip--;
      end else if (nlen > 0 && nlen <= NMAX && fill >= nlen) begin
        same = 1'b1;
        for (k = 0; k < nlen; k++)
          if (win[nlen - 1 - k] != needle_sh[k]) same = 1'b0;
        if (same) begin
          hit = 1'b1;
          skip = nlen - 1;
          if (occ_count != '1) occ_count++;
        end
      end
    end
    w.match_end = hit;
    w.count = occ_count;
    w.done = is_last;
    if (is_last) begin
      foreach (win[j]) win[j] = '0;
      fill = 0;
      skip = 0;
      occ_count = '0;
      stopped = 1'b0;
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [soc_pkg::COUNT_W-1:0] got,
                                 logic [soc_pkg::COUNT_W-1:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic send_byte(soc_pkg::byte_t d, bit l, bit typed, bit m,
                           logic [soc_pkg::COUNT_W-1:0] c);
    count_word_t w;
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 46 : (idle_mode == IDLE_BOTH) ? 9 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    w = scan_byte(d, l);
    if (typed) begin
      w.match_end = m;
      w.count = c;
    end
    pending_words.push_back(w);
  endtask

  // drain so that registers only change while the block is empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_needle(logic [63:0] lo, logic [63:0] hi, logic [63:0] len_word);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= soc_pkg::REG_NEEDLE_LO;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_addr  <= soc_pkg::REG_NEEDLE_HI;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_addr  <= soc_pkg::REG_NEEDLE_LEN;
    cfg_wdata <= len_word;
    @(posedge clk);
    cfg_addr  <= REG_SPARE;
    cfg_wdata <= {$urandom, $urandom};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    needle_sh = {hi, lo};
    nlen = len_word[soc_pkg::LEN_W-1:0];
  endtask

  function automatic script_row_t n_row(logic [63:0] lo, logic [63:0] hi, logic [63:0] lw);
    script_row_t r;
    r = '{ROW_NEEDLE, lo, hi, lw, 8'h00, 1'b0, 1'b0, 1'b0, '0};
    return r;
  endfunction

  function automatic script_row_t b_row(soc_pkg::byte_t d, bit l, bit typed = 1'b0,
                                        bit m = 1'b0,
                                        logic [soc_pkg::COUNT_W-1:0] c = '0);
    script_row_t r;
    r = '{ROW_BYTE, '0, '0, '0, d, l, typed, m, c};
    return r;
  endfunction

  // result side: check, then pick next ready
  always @(posedge clk) begin
    count_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word with nothing pending", out_tdata, '0);
      end else begin
        want = pending_words.pop_front();
        if (out_tuser[0] !== want.match_end)
          report_mismatch("match_end", out_tuser[0], want.match_end);
        if (out_tdata !== want.count)
          report_mismatch("running_count", out_tdata, want.count);
        if (out_tlast !== want.done)
          report_mismatch("buffer_done", out_tlast, want.done);
      end
    end
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: out_tready <= ($urandom_range(0, 99) >= 46);
        IDLE_BOTH:     out_tready <= ($urandom_range(0, 99) >= 9);
        default:       out_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    script_row_t      script [$];
    soc_pkg::byte_t   buf_bytes [$];
    soc_pkg::needle_t nd;
    logic [63:0]      len_word;
    int unsigned      blen;
    int unsigned      span;
    int unsigned      sent;
    int unsigned      r;
    bit               alpha;

    // empty needle straight after reset
    script.push_back(b_row(8'hFF, 1'b1, 1'b1, 1'b0, 0));
    // wide value on the length register keeps its low five bits: length 2, "aa"
    script.push_back(n_row(64'h6161, 64'h0, 64'hFFFF_FFFF_FFFF_FFE2));
    script.push_back(b_row(8'h61, 1'b0));
    script.push_back(b_row(8'h61, 1'b0));
    script.push_back(b_row(8'h61, 1'b0));
    script.push_back(b_row(8'h61, 1'b0));
    script.push_back(b_row(8'h00, 1'b0));   // terminator, search stops
    script.push_back(b_row(8'h61, 1'b1));
    // one-byte needle, every byte a hit
    script.push_back(n_row(64'hFF, 64'h0, 64'd1));
    script.push_back(b_row(8'hFF, 1'b0, 1'b1, 1'b1, 1));
    script.push_back(b_row(8'hFF, 1'b1, 1'b1, 1'b1, 2));
    // length beyond the needle store
    script.push_back(n_row('1, '1, 64'd17));
    script.push_back(b_row(8'hFF, 1'b1, 1'b1, 1'b0, 0));
    // full sixteen-byte needle 01..10
    script.push_back(n_row(64'h0807_0605_0403_0201, 64'h100F_0E0D_0C0B_0A09, 64'd16));
    for (int k = 1; k <= 16; k++)
      script.push_back(b_row(soc_pkg::byte_t'(k), k == 16, 1'b1, k == 16,
                             (k == 16) ? 1 : 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_NEEDLE) begin
        wait_idle();
        load_needle(script[i].lo, script[i].hi, script[i].len_word);
      end else begin
        send_byte(script[i].data, script[i].last, script[i].typed,
                  script[i].exp_match, script[i].exp_count);
      end
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_idle();
      alpha = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < NMAX; k++) begin
        if (!alpha) nd[k] = soc_pkg::byte_t'($urandom);
        else if ($urandom_range(0, 19) == 0) nd[k] = 8'h00;
        else nd[k] = 8'h61 + soc_pkg::byte_t'($urandom_range(0, 1));
      end
      case (phase % 8)
        0: len_word = 64'd16;
        1: len_word = 64'd0;
        2: len_word = {$urandom, $urandom};
        3: len_word = 64'($urandom_range(17, 31));
        default: len_word = 64'($urandom_range(1, 6));
      endcase
      load_needle(nd[7:0], nd[15:8], len_word);
      idle_mode = idle_mode_t'(phase % 4);
      if (phase == 4) hold_req = 1'b1;   // long receiver hold, sender keeps offering
      span = (nlen >= 1 && nlen <= NMAX) ? nlen : NMAX;

      sent = 0;
      while (sent < PHASE_BYTES) begin
        blen = $urandom_range(1, 24);
        buf_bytes.delete();
        while (buf_bytes.size() < blen) begin
          r = $urandom_range(0, 99);
          if (r < 30 && nlen >= 1 && nlen <= NMAX) begin
            for (int k = 0; k < nlen; k++) buf_bytes.push_back(needle_sh[k]);
          end else if (r < 33) begin
            buf_bytes.push_back(8'h00);
          end else if (r < 50) begin
            buf_bytes.push_back(soc_pkg::byte_t'($urandom));
          end else begin
            buf_bytes.push_back(needle_sh[$urandom_range(0, span - 1)]);
          end
        end
        foreach (buf_bytes[i])
          send_byte(buf_bytes[i], i == buf_bytes.size() - 1, 1'b0, 1'b0, '0);
        sent += buf_bytes.size();
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/soc_pkg.sv
design/soc_cell.sv
design/substring_occurrence_counter_top.sv
verif/tb_top.sv
